>>> src/fpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg
// Types and constants shared by the face pressure force accumulator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_WIND_X      = 8'd0;
    localparam logic [7:0] REG_WIND_Y      = 8'd1;
    localparam logic [7:0] REG_AIR_DENSITY = 8'd2;
    localparam logic [7:0] REG_PPM         = 8'd3;

    localparam logic [31:0] AIR_DENSITY_RST = 32'd80282;
    localparam logic [15:0] PPM_RST         = 16'd16;

    localparam logic [62:0] MAX63 = {63{1'b1}};

    // Fraction bits of the normal length
    localparam int MAG_FRAC = 16;

    localparam int DIV_W      = 80;
    localparam int DIV_STEPS  = DIV_W;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_DOT,
        S_PMUL,
        S_PDIV,
        S_ROOT,
        S_SQR,
        S_AIR,
        S_MAGM,
        S_FDIV,
        S_ACC,
        S_DONE,
        S_WSM,
        S_WROOT,
        S_OUT
    } state_t;

endpackage

>>> src/face_pressure_force_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_pressure_force_accumulator_unit
// Accumulates wind pressure force over the faces of an object.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one face normal per
//   transaction; last_face marks the final face of an object. Output channel
//   (out_valid / out_stall) carries one result per object: net force and
//   wind speed. The user must write configuration (cfg_valid / cfg_ready,
//   cfg_index, cfg_data) only while the block is idle; it does not enforce this.
//   Work: a face with a zero normal skips the force steps. Any other face
//   runs four 80-step restoring divisions (two for the projection, two by
//   the pixel scale) and one 32-step square root, all run through a single
//   33x33 multiplier, one divider and one root unit.
//   A last face adds the wind speed root.
//   in_stall is high for the whole time a face is at work.
//   The result sits in an output register; the next object's faces are
//   taken while it waits. If a new result is ready while the old one is
//   still stalled, the block holds until the old one is taken.
//   Reset clears the sums, restores the register defaults, empties the
//   output register and leaves the block idle.
// ----------------------------------------------------------------------------
module face_pressure_force_accumulator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic               last_face,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [62:0] force_x,
    output logic        [62:0] force_y,
    output logic        [31:0] wind_mag,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic         [7:0] cfg_index,
    input  logic        [31:0] cfg_data
);
    import fpfa_pkg::*;

    localparam int PR_SHIFT = FRAC_BITS + 1;
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic comp_reg, comp_next;
    logic step_last;

    logic [31:0] wind_x_reg, wind_y_reg, air_reg;
    logic [15:0] ppm_reg;
    logic [62:0] sum_x_reg, sum_y_reg;
    logic out_valid_reg;

    logic signed [15:0] nx_reg, ny_reg;
    logic last_reg;
    logic [31:0] sq_reg;
    logic signed [48:0] dot_reg;
    logic [127:0] acc_reg;
    logic [63:0] px_reg, py_reg, tmp_reg;
    logic [31:0] mag_reg;
    logic [62:0] pr_reg, f_reg;
    logic [DIV_W-1:0] div_num_reg;
    logic [31:0] div_rem_reg, div_den_reg;
    logic [63:0] rad_reg;
    logic [33:0] root_rem_reg;
    logic [31:0] root_reg;
    logic [31:0] ws_reg;
    logic [62:0] force_x_reg, force_y_reg;
    logic [31:0] wind_mag_reg;

    logic in_accept, out_take, out_load;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic mul_hi;
    logic [127:0] addend, acc_sum;
    logic [31:0] sq_sum;
    logic signed [48:0] dot_sum, dot_neg;
    logic [47:0] adot;
    logic [16:0] nx_ext, ny_ext, anx_w, any_w;
    logic [15:0] anx, any_v;
    logic [63:0] pcomp;
    logic [127:0] air_shr, mag_shr;
    logic [62:0] pr_val, f_val;
    logic [32:0] div_rem2;
    logic div_ge;
    logic [DIV_W-1:0] div_num_step;
    logic [31:0] div_rem_step;
    logic [35:0] root_sh, root_trial, root_diff;
    logic root_ge;
    logic [33:0] root_rem_step;
    logic [31:0] root_step;
    logic [15:0] ppm_eff;
    logic [63:0] sat_sum;
    logic [62:0] sum_sel, sum_new;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign force_x    = force_x_reg;
    assign force_y    = force_y_reg;
    assign wind_mag   = wind_mag_reg;

    // Magnitudes of the normal components and the dot product
    assign nx_ext  = {nx_reg[15], nx_reg};
    assign ny_ext  = {ny_reg[15], ny_reg};
    assign anx_w   = nx_reg[15] ? (17'd0 - nx_ext) : nx_ext;
    assign any_w   = ny_reg[15] ? (17'd0 - ny_ext) : ny_ext;
    assign anx     = anx_w[15:0];
    assign any_v   = any_w[15:0];
    assign dot_neg = -dot_reg;
    assign adot    = dot_reg[48] ? dot_neg[47:0] : dot_reg[47:0];
    assign pcomp   = comp_reg ? py_reg : px_reg;
    assign ppm_eff = (ppm_reg == 16'd0) ? 16'd1 : ppm_reg;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_hi = 1'b0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = cnt_reg[0] ? {{17{ny_reg[15]}}, ny_reg} : {{17{nx_reg[15]}}, nx_reg};
                mul_b = mul_a;
            end
            S_DOT:
            begin
                mul_a = cnt_reg[0] ? {{17{ny_reg[15]}}, ny_reg} : {{17{nx_reg[15]}}, nx_reg};
                mul_b = cnt_reg[0] ? {wind_y_reg[31], wind_y_reg}
                                   : {wind_x_reg[31], wind_x_reg};
            end
            S_PMUL:
            begin
                mul_a  = comp_reg ? {17'd0, any_v} : {17'd0, anx};
                mul_b  = cnt_reg[0] ? {17'd0, adot[47:32]} : {1'b0, adot[31:0]};
                mul_hi = cnt_reg[0];
            end
            S_SQR:
            begin
                mul_a  = (cnt_reg == CNT_W'(2)) ? {1'b0, pcomp[63:32]} : {1'b0, pcomp[31:0]};
                mul_b  = (cnt_reg == CNT_W'(1)) ? {1'b0, pcomp[63:32]} : {1'b0, pcomp[31:0]};
                mul_hi = (cnt_reg != '0);
            end
            S_AIR:
            begin
                mul_a  = cnt_reg[0] ? {1'b0, tmp_reg[63:32]} : {1'b0, tmp_reg[31:0]};
                mul_b  = {1'b0, air_reg};
                mul_hi = cnt_reg[0];
            end
            S_MAGM:
            begin
                mul_a  = cnt_reg[0] ? {2'b0, pr_reg[62:32]} : {1'b0, pr_reg[31:0]};
                mul_b  = {1'b0, mag_reg};
                mul_hi = cnt_reg[0];
            end
            S_WSM:
            begin
                mul_a = cnt_reg[0] ? {wind_y_reg[31], wind_y_reg}
                                   : {wind_x_reg[31], wind_x_reg};
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign addend  = mul_hi ? {32'd0, prod[63:0], 32'd0} : {64'd0, prod[63:0]};
    assign acc_sum = ((cnt_reg == '0) ? 128'd0 : acc_reg) + addend;
    assign sq_sum  = ((cnt_reg == '0) ? 32'd0 : sq_reg) + prod[31:0];
    assign dot_sum = ((cnt_reg == '0) ? 49'sd0 : dot_reg) + prod[48:0];

    assign air_shr = acc_sum >> PR_SHIFT;
    assign pr_val  = (|air_shr[127:63]) ? MAX63 : air_shr[62:0];
    assign mag_shr = acc_sum >> MAG_FRAC;

    // Restoring divider step
    assign div_rem2     = {div_rem_reg, div_num_reg[DIV_W-1]};
    assign div_ge       = div_rem2 >= {1'b0, div_den_reg};
    assign div_rem_step = div_ge ? 32'(div_rem2 - {1'b0, div_den_reg}) : div_rem2[31:0];
    assign div_num_step = {div_num_reg[DIV_W-2:0], div_ge};
    assign f_val        = (|div_num_step[DIV_W-1:63]) ? MAX63 : div_num_step[62:0];

    // Digit-by-digit square root step
    assign root_sh       = {root_rem_reg, rad_reg[63:62]};
    assign root_trial    = {2'b0, root_reg, 2'b01};
    assign root_ge       = root_sh >= root_trial;
    assign root_diff     = root_sh - root_trial;
    assign root_rem_step = root_ge ? root_diff[33:0] : root_sh[33:0];
    assign root_step     = {root_reg[30:0], root_ge};

    // Saturating accumulate
    assign sum_sel = comp_reg ? sum_y_reg : sum_x_reg;
    assign sat_sum = {1'b0, sum_sel} + {1'b0, f_reg};
    assign sum_new = sat_sum[63] ? MAX63 : sat_sum[62:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        step_last  = 1'b0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:      step_last = 1'b0;
            S_SQ, S_DOT, S_PMUL, S_AIR, S_MAGM, S_WSM:
                         step_last = (cnt_reg == CNT_W'(1));
            S_SQR:       step_last = (cnt_reg == CNT_W'(2));
            S_PDIV, S_FDIV:
                         step_last = (cnt_reg == DIV_LAST);
            S_ROOT, S_WROOT:
                         step_last = (cnt_reg == SQRT_LAST);
            default:     step_last = 1'b1;
        endcase
        if (state_reg != S_IDLE && state_reg != S_OUT)
        begin
            cnt_next = step_last ? '0 : cnt_reg + CNT_W'(1);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_SQ;
                    cnt_next   = '0;
                end
            end
            S_SQ:
            begin
                if (step_last)
                begin
                    state_next = (sq_sum == 32'd0) ? S_DONE : S_DOT;
                end
            end
            S_DOT:
            begin
                if (step_last)
                begin
                    state_next = S_PMUL;
                    comp_next  = 1'b0;
                end
            end
            S_PMUL:  if (step_last) state_next = S_PDIV;
            S_PDIV:
            begin
                if (step_last)
                begin
                    state_next = comp_reg ? S_ROOT : S_PMUL;
                    comp_next  = !comp_reg;
                end
            end
            S_ROOT:  if (step_last) state_next = S_SQR;
            S_SQR:   if (step_last) state_next = S_AIR;
            S_AIR:   if (step_last) state_next = S_MAGM;
            S_MAGM:  if (step_last) state_next = S_FDIV;
            S_FDIV:  if (step_last) state_next = S_ACC;
            S_ACC:
            begin
                state_next = comp_reg ? S_DONE : S_SQR;
                comp_next  = !comp_reg;
            end
            S_DONE:  state_next = last_reg ? S_WSM : S_IDLE;
            S_WSM:   if (step_last) state_next = S_WROOT;
            S_WROOT: if (step_last) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= 1'b0;
            wind_x_reg    <= '0;
            wind_y_reg    <= '0;
            air_reg       <= AIR_DENSITY_RST;
            ppm_reg       <= PPM_RST;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIND_X:      wind_x_reg <= cfg_data;
                    REG_WIND_Y:      wind_y_reg <= cfg_data;
                    REG_AIR_DENSITY: air_reg    <= cfg_data;
                    REG_PPM:         ppm_reg    <= cfg_data[15:0];
                    default:         ppm_reg    <= ppm_reg;
                endcase
            end
            if (state_reg == S_ACC)
            begin
                if (comp_reg)
                    sum_y_reg <= sum_new;
                else
                    sum_x_reg <= sum_new;
            end
            // Clear the sums once the result is captured
            if (out_load)
            begin
                sum_x_reg     <= '0;
                sum_y_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            nx_reg   <= normal_x;
            ny_reg   <= normal_y;
            last_reg <= last_face;
        end
        case (state_reg)
            S_SQ:
            begin
                sq_reg <= sq_sum;
            end
            S_DOT:
            begin
                dot_reg <= dot_sum;
            end
            S_PMUL:
            begin
                acc_reg <= acc_sum;
                if (step_last)
                begin
                    div_num_reg <= {16'd0, acc_sum[63:0]};
                    div_rem_reg <= '0;
                    div_den_reg <= sq_reg;
                end
            end
            S_PDIV, S_FDIV:
            begin
                div_num_reg <= div_num_step;
                div_rem_reg <= div_rem_step;
                if (step_last && state_reg == S_FDIV)
                    f_reg <= f_val;
                if (step_last && state_reg == S_PDIV)
                begin
                    if (comp_reg)
                        py_reg <= div_num_step[63:0];
                    else
                        px_reg <= div_num_step[63:0];
                    // Prime the root unit with the squared length, shifted up
                    rad_reg      <= {sq_reg, 32'd0};
                    root_rem_reg <= '0;
                    root_reg     <= '0;
                end
            end
            S_ROOT, S_WROOT:
            begin
                rad_reg      <= rad_reg << 2;
                root_rem_reg <= root_rem_step;
                root_reg     <= root_step;
                if (step_last && state_reg == S_ROOT)
                    mag_reg <= root_step;
                if (step_last && state_reg == S_WROOT)
                    ws_reg <= root_step;
            end
            S_SQR:
            begin
                acc_reg <= acc_sum;
                if (step_last)
                    tmp_reg <= acc_sum[63:0];
            end
            S_AIR:
            begin
                acc_reg <= acc_sum;
                if (step_last)
                    pr_reg <= pr_val;
            end
            S_MAGM:
            begin
                acc_reg <= acc_sum;
                if (step_last)
                begin
                    div_num_reg <= mag_shr[DIV_W-1:0];
                    div_rem_reg <= '0;
                    div_den_reg <= {16'd0, ppm_eff};
                end
            end
            S_WSM:
            begin
                acc_reg <= acc_sum;
                if (step_last)
                begin
                    rad_reg      <= acc_sum[63:0];
                    root_rem_reg <= '0;
                    root_reg     <= '0;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    force_x_reg  <= sum_x_reg;
                    force_y_reg  <= sum_y_reg;
                    wind_mag_reg <= ws_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_out_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> last_reg)
        else $error("result stage entered for a face not marked last");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sum_x_reg == '0 && sum_y_reg == '0))
        else $error("sums not cleared after result capture");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PDIV || state_reg == S_FDIV) |-> (div_rem_reg < div_den_reg))
        else $error("divider remainder out of range");

    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PDIV || state_reg == S_FDIV) |-> (div_den_reg != '0))
        else $error("divider running with zero divisor");
`endif

endmodule

>>> bench/face_pressure_force_accumulator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_pressure_force_accumulator_unit_test
// Self-checking bench: face normals stream in, grouped into objects. A
// predictor sums each face's wind pressure force and checks every net force
// and wind speed result. It runs through several wind, density and scale
// settings with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module face_pressure_force_accumulator_unit_test;
    import fpfa_pkg::*;

    localparam int FRAC  = 16;
    localparam int LIMIT = 8000000;
    localparam int SETTLE = 600;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic               last;
    } face_t;

    typedef struct packed {
        logic [62:0] fx;
        logic [62:0] fy;
        logic [31:0] ws;
    } force_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] normal_x = '0;
    logic signed [15:0] normal_y = '0;
    logic               last_face = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic        [62:0] force_x;
    logic        [62:0] force_y;
    logic        [31:0] wind_mag;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic         [7:0] cfg_index = '0;
    logic        [31:0] cfg_data = '0;

    face_t  face_feed[$];
    force_t force_expected[$];

    // predictor copy of the registers and sums
    logic [31:0] wind_x_r   = '0;
    logic [31:0] wind_y_r   = '0;
    logic [31:0] density_r  = AIR_DENSITY_RST;
    logic [15:0] ppm_r      = PPM_RST;
    logic [63:0] sum_x = '0;
    logic [63:0] sum_y = '0;

    int  idle_pct = 38;
    bit  failed = 1'b0;
    int  cycles = 0;
    logic rx_hold_req = 1'b0;
    int  rx_hold_cnt = 0;

    face_pressure_force_accumulator_unit dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] sat63(logic [127:0] t);
        return (t > {65'd0, MAX63}) ? {1'b0, MAX63} : t[63:0];
    endfunction

    function automatic logic [63:0] face_push(logic [63:0] pmag, logic [63:0] mag,
                                              logic [63:0] ppm);
        logic [63:0]  p2;
        logic [63:0]  pr;
        logic [127:0] t;
        p2 = pmag * pmag;   // wraps at 64 bits, as the block's square does
        t = {64'd0, p2} * {96'd0, density_r};
        t = t >> (FRAC + 1);
        pr = sat63(t);
        t = {64'd0, pr} * {64'd0, mag};
        t = t >> MAG_FRAC;
        t = t / {64'd0, ppm};
        return sat63(t);
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > {1'b0, MAX63}) ? {1'b0, MAX63} : s;
    endfunction

    // Fold one accepted face into the sums; queue a result on a last face.
    task automatic accumulate_face(face_t f);
        longint nx, ny, wx, wy, dot;
        logic [63:0] sq, adot, anx, any, px, py, mag, ppm, ws;
        force_t r;
        nx = f.nx;
        ny = f.ny;
        wx = $signed(wind_x_r);
        wy = $signed(wind_y_r);
        sq = nx * nx + ny * ny;
        if (sq != 0)
        begin
            dot = nx * wx + ny * wy;
            adot = dot < 0 ? -dot : dot;
            anx = nx < 0 ? -nx : nx;
            any = ny < 0 ? -ny : ny;
            px = anx * adot / sq;
            py = any * adot / sq;
            mag = isqrt(sq << 32);
            ppm = (ppm_r == 0) ? 64'd1 : {48'd0, ppm_r};
            sum_x = add_sat(sum_x, face_push(px, mag, ppm));
            sum_y = add_sat(sum_y, face_push(py, mag, ppm));
        end
        if (f.last)
        begin
            ws = isqrt(wx * wx + wy * wy);
            r.fx = sum_x[62:0];
            r.fy = sum_y[62:0];
            r.ws = (ws > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ws[31:0];
            force_expected.push_back(r);
            sum_x = '0;
            sum_y = '0;
        end
    endtask

    // input driver
    always @(posedge clk)
    begin
        face_t f;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                accumulate_face({normal_x, normal_y, last_face});
            if (!in_valid || !in_stall)
            begin
                if (face_feed.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    f = face_feed.pop_front();
                    in_valid  <= 1'b1;
                    normal_x  <= f.nx;
                    normal_y  <= f.ny;
                    last_face <= f.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (rx_hold_req)
            rx_hold_cnt <= 12000;
        else if (rx_hold_cnt > 0)
            rx_hold_cnt <= rx_hold_cnt - 1;
    end

    // output monitor
    always @(posedge clk)
    begin
        force_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (force_expected.size() == 0)
                begin
                    $display("%0t: unexpected result fx=%h fy=%h ws=%h",
                             $time, force_x, force_y, wind_mag);
                    failed = 1'b1;
                end
                else
                begin
                    e = force_expected.pop_front();
                    if (force_x !== e.fx)
                    begin
                        $display("%0t: force_x expected %h actual %h", $time, e.fx, force_x);
                        failed = 1'b1;
                    end
                    if (force_y !== e.fy)
                    begin
                        $display("%0t: force_y expected %h actual %h", $time, e.fy, force_y);
                        failed = 1'b1;
                    end
                    if (wind_mag !== e.ws)
                    begin
                        $display("%0t: wind_mag expected %h actual %h",
                                 $time, e.ws, wind_mag);
                        failed = 1'b1;
                    end
                end
            end
            out_stall <= (rx_hold_cnt > 0) || ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WIND_X:      wind_x_r  = data;
            REG_WIND_Y:      wind_y_r  = data;
            REG_AIR_DENSITY: density_r = data;
            REG_PPM:         ppm_r     = data[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (face_feed.size() > 0 || in_valid || force_expected.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_wind(logic [31:0] wx, logic [31:0] wy, logic [31:0] rho,
                            logic [31:0] ppm);
        write_reg(REG_WIND_X, wx);
        write_reg(REG_WIND_Y, wy);
        write_reg(REG_AIR_DENSITY, rho);
        write_reg(REG_PPM, ppm);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            2, 3, 4: return 16'($signed($urandom_range(100)) - 50);
            default: return 16'($urandom);
        endcase
    endfunction

    // Objects of one to six faces, each ending in a last face.
    task automatic queue_objects(int n_faces);
        int left;
        int len;
        face_t f;
        left = n_faces;
        while (left > 0)
        begin
            len = $urandom_range(6, 1);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                f.nx = rand_comp();
                f.ny = rand_comp();
                f.last = (i == len - 1);
                face_feed.push_back(f);
            end
            left -= len;
        end
    endtask

    task automatic queue_face(logic [15:0] nx, logic [15:0] ny, logic last);
        face_feed.push_back({nx, ny, last});
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, then extremes of normals
        queue_face(16'h0000, 16'h0000, 1'b1);
        queue_face(16'h7FFF, 16'h8000, 1'b0);
        queue_face(16'h8000, 16'h7FFF, 1'b1);
        drain();
        set_wind(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1);
        queue_face(16'h7FFF, 16'h7FFF, 1'b0);
        queue_face(16'h8000, 16'h8000, 1'b0);
        queue_face(16'h0000, 16'h0000, 1'b0);
        queue_face(16'h8000, 16'h0000, 1'b1);
        queue_face(16'h0000, 16'h0000, 1'b1);
        queue_face(16'h0001, 16'hFFFF, 1'b1);
        drain();
        set_wind(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd65535);
        queue_face(16'h0003, 16'h0004, 1'b1);
        queue_face(16'h8000, 16'h8000, 1'b1);
        drain();
        // zero scale falls back to one
        set_wind(32'h0003_0000, 32'hFFFE_8000, 32'd80282, 32'd0);
        queue_face(16'h0005, 16'hFFF4, 1'b0);
        queue_face(16'hFFFF, 16'h0000, 1'b1);
        queue_face(16'h0000, 16'h0001, 1'b1);
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 3 == 0)
                set_wind($urandom_range(40 << 16), -$urandom_range(40 << 16),
                         $urandom_range(3 << 16), $urandom_range(64, 1));
            else
                set_wind($urandom, $urandom, $urandom, $urandom_range(65535));
            idle_pct = (ph == 2) ? 0 : 38;
            if (ph == 5)
            begin
                @(posedge clk);
                rx_hold_req <= 1'b1;
                @(posedge clk);
                rx_hold_req <= 1'b0;
            end
            queue_objects(185);
            drain();
        end
        idle_pct = 38;

        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
src/fpfa_pkg.sv
src/face_pressure_force_accumulator_unit.sv
bench/face_pressure_force_accumulator_unit_test.sv
